[hdl/rlfe_pkg.sv]
package rlfe_pkg;

  // command codes carried in the op field
  typedef enum logic [1:0] {
    OP_STAGE  = 2'd0,
    OP_START  = 2'd1,
    OP_ERROR  = 2'd2,
    OP_RENDER = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] CFG_TICKS      = 2'd1;
  localparam logic [1:0] CFG_INTERVAL   = 2'd2;

  localparam logic [8:0]  RESET_BRIGHTNESS = 9'd25;
  localparam logic [19:0] RESET_TICKS      = 20'd1000;
  localparam logic [9:0]  RESET_INTERVAL   = 10'd20;
  localparam logic [29:0] RESET_PERIOD     = 30'd20000;
  localparam logic [26:0] RESET_GAP        = 27'd2000;

  // fade factor is an 8-bit fraction of full scale
  localparam int          FACTOR_BITS = 8;
  localparam logic [8:0]  FULL_SCALE  = 9'd256;
  localparam logic [7:0]  LEVEL_ON    = 8'hFF;

  // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int          ERROR_LEDS  = 4;

endpackage

[hdl/rlfe_div.sv]
module rlfe_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [31:0]                        dividend,
  input  logic [31:0]                        divisor,
  output logic                               done,
  output logic [rlfe_pkg::FACTOR_BITS-1:0]   quotient
);

  localparam int CW = $clog2(rlfe_pkg::FACTOR_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(rlfe_pkg::FACTOR_BITS - 1);

  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [33:0]   diff;
  logic          fits;

  // restoring step: shift remainder, try subtracting divisor
  assign diff = {1'b0, rem, 1'b0} - {2'b00, dvs};
  assign fits = ~diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= diff[31:0];
        end else begin
          rem <= {rem[30:0], 1'b0};
        end
        quotient <= {quotient[rlfe_pkg::FACTOR_BITS-2:0], fits};
        cnt      <= CW'(cnt + 1'b1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/rgb_led_fade_engine.sv]
// rgb led fade engine
//
// keeps start, target and staged color bytes for LED_COUNT rgb leds
// (3*LED_COUNT bytes) and renders them with a linear fade and a global
// brightness scale.
// input channel (in_valid/in_ready): one word is a command. stage writes
//   a staged byte and the block stays idle. start copies staged to target
//   in a sweep of read and emit steps per byte; a fade also re-blends the
//   start colors with read, multiply and emit steps per byte, after factor,
//   weights and fade length. error writes the target bytes in turn. render
//   (mode not idle) streams a word per color byte, last on the final byte.
// output channel (out_valid/out_ready): one registered word. a render
//   works out factor and weights, then passes each byte through the shared
//   multiplier. the block takes no new word until the sweep ends.
// a stalled receiver holds the sweep at the emit step; the last byte
//   sits in the output register while the next command is taken.
// reset: leds dark, mode idle, registers back to 25 / 1000 / 20.
// config writes (cfg_we/cfg_index/cfg_data): the user makes them while idle
//   only; the block does not enforce it. commands wait for period and gap.
module rgb_led_fade_engine #(
  parameter int LED_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  // command words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  index,
  input  logic [7:0]  value,
  input  logic [15:0] duration_ms,
  input  logic [3:0]  error_bits,
  input  logic [31:0] now,
  // level words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  position,
  output logic [7:0]  level,
  output logic        last,
  output logic [31:0] next_frame
);

  localparam int NBYTES = 3 * LED_COUNT;
  localparam int IW     = $clog2(NBYTES);
  localparam logic [IW-1:0] LAST_BYTE = IW'(NBYTES - 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IMMEDIATE,
    MODE_LINEAR
  } mode_t;

  // what a byte sweep does with each byte
  typedef enum logic [1:0] {
    K_COPY,
    K_FADE,
    K_ERR,
    K_RENDER
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACT,
    S_DIV,
    S_W0,
    S_W1,
    S_DUR,
    S_RD,
    S_M0,
    S_M1,
    S_EMIT,
    S_CLR
  } state_t;

  state_t state;
  kind_t  kind;
  mode_t  mode;

  // configuration and derived timing
  logic [8:0]  brightness;
  logic [19:0] tick_rate;
  logic [9:0]  update_interval_ms;
  logic [29:0] period;      // update interval in ticks
  logic [26:0] gap;         // period / 10
  logic [63:0] gap_prod;
  logic [1:0]  cfg_settle;  // cycles until period and gap follow a write

  // fade timing
  logic [31:0] start_time;
  logic [31:0] end_time;

  // captured command
  logic [31:0] now_q;
  logic [15:0] dur_q;
  logic [3:0]  err_q;

  // sweep
  logic [IW-1:0] i;
  logic [8:0]    f_q;
  logic [8:0]    scale_q;
  logic [16:0]   w0;
  logic [16:0]   w1;
  logic [23:0]   acc;
  logic [31:0]   next_q;

  // color stores
  logic [7:0] start_mem  [NBYTES];
  logic [7:0] target_mem [NBYTES];
  logic [7:0] staged_mem [NBYTES];
  logic [NBYTES-1:0] start_valid;
  logic [NBYTES-1:0] target_valid;
  logic [7:0] start_q;
  logic [7:0] target_q;
  logic [7:0] staged_q;
  logic       start_vq;
  logic       target_vq;

  logic        accept;
  logic        staged_we;
  logic        start_we;
  logic        target_we;
  logic [7:0]  target_wdata;
  logic [7:0]  err_level;
  logic [7:0]  s_eff;
  logic [7:0]  t_eff;
  logic [8:0]  b_eff;
  logic [31:0] delta;
  logic [31:0] span;
  logic [31:0] gap_end;
  logic [31:0] fade_next;
  logic [19:0] mul_a;
  logic [16:0] mul_b;
  logic [36:0] prod;
  logic        div_start;
  logic        div_done;
  logic [rlfe_pkg::FACTOR_BITS-1:0] div_q;
  logic        emit_ok;

  assign in_ready = (state == S_IDLE) && (cfg_settle == 2'd0);
  assign accept   = in_valid && in_ready;

  // brightness above full acts as full
  assign b_eff = brightness[8] ? rlfe_pkg::FULL_SCALE : brightness;

  assign delta     = now_q - start_time;
  assign span      = end_time - start_time;
  assign gap_end   = now + 32'(gap);
  assign fade_next = now_q + 32'(period);
  assign gap_prod  = 64'(period) * 64'(rlfe_pkg::RECIP_TEN);

  // never-written start / target bytes read as zero
  assign s_eff = start_vq  ? start_q  : 8'd0;
  assign t_eff = target_vq ? target_q : 8'd0;

  // the one shared multiplier: weights, fade length, per-byte blend
  always_comb begin
    case (state)
      S_W0: begin
        mul_a = 20'(9'(rlfe_pkg::FULL_SCALE - f_q));
        mul_b = 17'(scale_q);
      end
      S_W1: begin
        mul_a = 20'(f_q);
        mul_b = 17'(scale_q);
      end
      S_DUR: begin
        mul_a = tick_rate;
        mul_b = 17'(dur_q);
      end
      S_M0: begin
        mul_a = 20'(s_eff);
        mul_b = w0;
      end
      default: begin
        mul_a = 20'(t_eff);
        mul_b = w1;
      end
    endcase
  end

  assign prod = {17'd0, mul_a} * {20'd0, mul_b};

  // error pattern: first channel of each of the four leds
  always_comb begin
    err_level = 8'd0;
    for (int k = 0; k < rlfe_pkg::ERROR_LEDS; k++) begin
      if (i == IW'(3 * k) && err_q[k]) begin
        err_level = rlfe_pkg::LEVEL_ON;
      end
    end
  end

  assign staged_we = accept && (op == rlfe_pkg::OP_STAGE) && (32'(index) < NBYTES);
  assign start_we  = (state == S_EMIT) && (kind == K_FADE);
  assign target_we = ((state == S_EMIT) && (kind == K_FADE || kind == K_COPY)) ||
                     (state == S_CLR);
  assign target_wdata = (state == S_CLR) ? err_level : staged_q;

  assign div_start = (state == S_FACT) && (delta < span);
  assign emit_ok   = !out_valid || out_ready;

  rlfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delta),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  // color memories, one read address (the sweep index) each
  always_ff @(posedge clk) begin
    start_q  <= start_mem[i];
    target_q <= target_mem[i];
    staged_q <= staged_mem[i];
    if (start_we) begin
      start_mem[i] <= acc[23:16];
    end
    if (target_we) begin
      target_mem[i] <= target_wdata;
    end
    if (staged_we) begin
      staged_mem[IW'(index)] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_valid  <= '0;
      target_valid <= '0;
      start_vq     <= 1'b0;
      target_vq    <= 1'b0;
    end else begin
      if (start_we) begin
        start_valid[i] <= 1'b1;
      end
      if (target_we) begin
        target_valid[i] <= 1'b1;
      end
      start_vq  <= start_valid[i];
      target_vq <= target_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      kind               <= K_COPY;
      mode               <= MODE_IDLE;
      start_time         <= '0;
      end_time           <= '0;
      brightness         <= rlfe_pkg::RESET_BRIGHTNESS;
      tick_rate          <= rlfe_pkg::RESET_TICKS;
      update_interval_ms <= rlfe_pkg::RESET_INTERVAL;
      period             <= rlfe_pkg::RESET_PERIOD;
      gap                <= rlfe_pkg::RESET_GAP;
      cfg_settle         <= '0;
      i                  <= '0;
      out_valid          <= 1'b0;
    end else begin
      // period follows the registers after a write, and gap follows period
      period <= 30'(update_interval_ms) * 30'(tick_rate);
      gap    <= gap_prod[rlfe_pkg::RECIP_SHIFT+26:rlfe_pkg::RECIP_SHIFT];

      if (cfg_we) begin
        case (cfg_index)
          rlfe_pkg::CFG_BRIGHTNESS: brightness         <= cfg_data[8:0];
          rlfe_pkg::CFG_TICKS:      tick_rate          <= cfg_data;
          rlfe_pkg::CFG_INTERVAL:   update_interval_ms <= cfg_data[9:0];
          default: ;
        endcase
        cfg_settle <= 2'd2;
      end else if (cfg_settle != 2'd0) begin
        cfg_settle <= cfg_settle - 2'd1;
      end

      // a word taken while the next one is emitted is replaced, not cleared
      if (out_valid && out_ready && !(state == S_EMIT && kind == K_RENDER)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            now_q <= now;
            dur_q <= duration_ms;
            err_q <= error_bits;
            i     <= '0;
            case (op)
              rlfe_pkg::OP_START: begin
                if (duration_ms == 16'd0) begin
                  kind       <= K_COPY;
                  start_time <= now;
                  end_time   <= now;
                  mode       <= MODE_IMMEDIATE;
                  state      <= S_RD;
                end else begin
                  // a running fade is resampled as the new start colors
                  kind    <= K_FADE;
                  scale_q <= rlfe_pkg::FULL_SCALE;
                  if (mode == MODE_LINEAR) begin
                    state <= S_FACT;
                  end else begin
                    f_q   <= rlfe_pkg::FULL_SCALE;
                    state <= S_W0;
                  end
                end
              end
              rlfe_pkg::OP_ERROR: begin
                kind       <= K_ERR;
                start_time <= now;
                end_time   <= now;
                mode       <= MODE_IMMEDIATE;
                state      <= S_CLR;
              end
              rlfe_pkg::OP_RENDER: begin
                if (mode != MODE_IDLE) begin
                  kind    <= K_RENDER;
                  scale_q <= b_eff;
                  if (gap_end > end_time) begin
                    // transition over: show target, go idle
                    mode   <= MODE_IDLE;
                    f_q    <= rlfe_pkg::FULL_SCALE;
                    next_q <= now;
                    state  <= S_W0;
                  end else if (mode == MODE_LINEAR) begin
                    state <= S_FACT;
                  end else begin
                    f_q    <= rlfe_pkg::FULL_SCALE;
                    next_q <= end_time;
                    state  <= S_W0;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_FACT: begin
          next_q <= (fade_next > end_time) ? end_time : fade_next;
          if (delta >= span) begin
            f_q   <= rlfe_pkg::FULL_SCALE;
            state <= S_W0;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            f_q   <= {1'b0, div_q};
            state <= S_W0;
          end
        end

        S_W0: begin
          w0    <= prod[16:0];
          state <= S_W1;
        end

        S_W1: begin
          w1    <= prod[16:0];
          state <= (kind == K_FADE) ? S_DUR : S_RD;
        end

        S_DUR: begin
          end_time   <= now_q + prod[31:0];
          start_time <= now_q;
          mode       <= MODE_LINEAR;
          state      <= S_RD;
        end

        S_RD: begin
          state <= (kind == K_COPY) ? S_EMIT : S_M0;
        end

        S_M0: begin
          acc   <= prod[23:0];
          state <= S_M1;
        end

        S_M1: begin
          acc   <= acc + prod[23:0];
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (kind != K_RENDER || emit_ok) begin
            if (kind == K_RENDER) begin
              out_valid  <= 1'b1;
              position   <= i[3:0];
              level      <= acc[23:16];
              last       <= (i == LAST_BYTE);
              next_frame <= next_q;
            end
            if (i == LAST_BYTE) begin
              state <= S_IDLE;
            end else begin
              i     <= IW'(i + 1'b1);
              state <= S_RD;
            end
          end
        end

        S_CLR: begin
          if (i == LAST_BYTE) begin
            state <= S_IDLE;
          end else begin
            i <= IW'(i + 1'b1);
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/rlfe_checker.sv]
module rlfe_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  position,
  input  logic [7:0]  level,
  input  logic        last,
  input  logic [31:0] next_frame
);

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(position) &&
                                $stable(last) && $stable(next_frame))
    else $error("output word changed while stalled");

  // staging leaves the block ready
  a_stage_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == rlfe_pkg::OP_STAGE |=> in_ready)
    else $error("stage command left the block busy");

  // a start always runs a byte sweep
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == rlfe_pkg::OP_START |=> !in_ready)
    else $error("start command did not sweep");

  // mid-frame the block takes no commands
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("command taken during a frame");

  // nothing follows the final byte straight away
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid)
    else $error("word right after end of frame");

endmodule

bind rgb_led_fade_engine rlfe_checker u_rlfe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .op         (op),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .position   (position),
  .level      (level),
  .last       (last),
  .next_frame (next_frame)
);
